// ----- hdl/lpmf_pkg.sv -----
package lpmf_pkg;

   // Field widths of the channels.
   localparam int OP_BITS     = 2;
   localparam int VALUE_BITS  = 32;
   localparam int KIND_BITS   = 2;
   localparam int STATUS_BITS = 2;
   localparam int DROP_BITS   = 16;
   localparam int LEN_BITS    = 6;

   // Input operation codes.
   localparam logic [OP_BITS-1:0] OP_BEGIN  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_DATA   = 2'd1;
   localparam logic [OP_BITS-1:0] OP_READ   = 2'd2;
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

   // Result kinds.
   localparam logic [KIND_BITS-1:0] KIND_SEND   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_HEADER = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_DATA   = 2'd2;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_DROPPED   = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_TOO_LARGE = 2'd3;

   // A classified command as it travels from the front end to the back end.
   typedef struct packed {
      logic [OP_BITS-1:0]    op;
      logic [VALUE_BITS-1:0] value;
      logic                  over_max;
      logic                  zero_len;
   } cmd_type;

   // Saturating increment of the drop counter.
   function automatic logic [DROP_BITS-1:0] sat_inc(input logic [DROP_BITS-1:0] count,
                                                    input logic enable);
      return (enable && (count != {DROP_BITS{1'b1}})) ? count + 1'b1 : count;
   endfunction

endpackage

// ----- hdl/lpmf_req_if.sv -----
interface lpmf_req_if import lpmf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OP_BITS-1:0]    op;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink (input valid, input op, input value, output ready);
endinterface

// ----- hdl/lpmf_rsp_if.sv -----
interface lpmf_rsp_if import lpmf_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [KIND_BITS-1:0]   kind;
   logic [STATUS_BITS-1:0] status;
   logic [VALUE_BITS-1:0]  value_res;
   logic                   last;
   logic [DROP_BITS-1:0]   drop_count;

   modport source (output valid, output kind, output status, output value_res,
                   output last, output drop_count, input ready);
   modport sink (input valid, input kind, input status, input value_res,
                 input last, input drop_count, output ready);
endinterface

// ----- hdl/length_prefixed_message_fifo_top.sv -----
// A send item or an empty read passes through the command queue and the output register
// before its result appears; a successful read also passes the registered read port of
// the ring memory before its header, then gives one word a cycle unless the output stalls.
// Send items go one per cycle unless the output stalls; no command is taken during a read.
// Reset is synchronous and clears positions, counters, queue and output; ring memory is not
// cleared, and no clearing pass runs, so items are taken from the first cycle after reset.
module length_prefixed_message_fifo_top import lpmf_pkg::*; #(
   parameter int RING_WORDS        = 256,
   parameter int WORD_BITS         = 32,
   parameter int MAX_MESSAGE_WORDS = 63
) (
   input logic        clock,
   input logic        reset,
   lpmf_req_if.sink   req,
   lpmf_rsp_if.source rsp
);

   logic    push;
   cmd_type push_data;
   logic    full;
   logic    pop;
   cmd_type head;
   logic    head_valid;

   // Front end: takes and classifies items.
   lpmf_front #(
      .MAX_MESSAGE_WORDS (MAX_MESSAGE_WORDS)
   ) u_front (
      .req       (req),
      .full      (full),
      .push      (push),
      .push_data (push_data)
   );

   // Short command queue between front and back ends.
   lpmf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (full),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   // Back end: ring store, positions and result generation.
   lpmf_back #(
      .RING_WORDS (RING_WORDS),
      .WORD_BITS  (WORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

// ----- hdl/lpmf_ram.sv -----
module lpmf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port; the read data holds when idle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/lpmf_front.sv -----
module lpmf_front import lpmf_pkg::*; #(
   parameter int MAX_MESSAGE_WORDS = 63
) (
   lpmf_req_if.sink req,
   input  logic     full,
   output logic     push,
   output cmd_type  push_data
);

   // The front end takes an item whenever the queue has room.
   assign req.ready = !full;

   // Classify the item; unused codes are taken and dropped here.
   always_comb begin
      push               = 1'b0;
      push_data.op       = req.op;
      push_data.value    = req.value;
      push_data.over_max = req.value > VALUE_BITS'(MAX_MESSAGE_WORDS);
      push_data.zero_len = req.value == '0;
      unique case (req.op) inside
         OP_BEGIN, OP_DATA, OP_READ: begin
            push = req.valid && !full;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule

// ----- hdl/lpmf_queue.sv -----
module lpmf_queue import lpmf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    head_valid
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head       = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/lpmf_back.sv -----
module lpmf_back import lpmf_pkg::*; #(
   parameter int RING_WORDS = 256,
   parameter int WORD_BITS  = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head,
   input  logic       head_valid,
   output logic       pop,
   lpmf_rsp_if.source rsp
);

   localparam int PTR_BITS = $clog2(RING_WORDS);
   localparam int OUT_BITS = (WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_HDR    = 2'd1;
   localparam logic [1:0] S_STREAM = 2'd2;

   // Next ring slot, wrapping at the ring size.
   function automatic logic [PTR_BITS-1:0] adv(input logic [PTR_BITS-1:0] p);
      return (p == PTR_BITS'(RING_WORDS - 1)) ? '0 : p + 1'b1;
   endfunction

   logic [1:0]             state_ff, state_in;
   logic [PTR_BITS-1:0]    rp_ff, rp_in;
   logic [PTR_BITS-1:0]    cwp_ff, cwp_in;
   logic [PTR_BITS-1:0]    pwp_ff, pwp_in;
   logic [LEN_BITS-1:0]    wr_ff, wr_in;
   logic                   disc_ff, disc_in;
   logic [DROP_BITS-1:0]   drops_ff, drops_in;
   logic [VALUE_BITS-1:0]  limit_ff, limit_in;
   logic [LEN_BITS-1:0]    remain_ff, remain_in;

   logic                   out_valid_ff, out_valid_in;
   logic [KIND_BITS-1:0]   out_kind_ff, out_kind_in;
   logic [STATUS_BITS-1:0] out_status_ff, out_status_in;
   logic [VALUE_BITS-1:0]  out_value_ff, out_value_in;
   logic                   out_last_ff, out_last_in;
   logic [DROP_BITS-1:0]   out_drops_ff, out_drops_in;

   logic                   can_load;
   logic [DROP_BITS-1:0]   drops_mid;
   logic [LEN_BITS-1:0]    wr_dec;
   logic [LEN_BITS-1:0]    hdr_len;
   logic [PTR_BITS-1:0]    rp_adv, cwp_adv, pwp_adv;

   logic                   ram_wr_en;
   logic [PTR_BITS-1:0]    ram_wr_addr;
   logic [WORD_BITS-1:0]   ram_wr_data;
   logic                   ram_rd_en;
   logic [PTR_BITS-1:0]    ram_rd_addr;
   logic [WORD_BITS-1:0]   ram_rd_data;

   lpmf_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (RING_WORDS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign can_load = !out_valid_ff || rsp.ready;
   assign hdr_len  = ram_rd_data[LEN_BITS-1:0];
   assign wr_dec   = wr_ff - 1'b1;
   assign rp_adv   = adv(rp_ff);
   assign cwp_adv  = adv(cwp_ff);
   assign pwp_adv  = adv(pwp_ff);

   // Command execution and result generation.
   always_comb begin
      state_in      = state_ff;
      rp_in         = rp_ff;
      cwp_in        = cwp_ff;
      pwp_in        = pwp_ff;
      wr_in         = wr_ff;
      disc_in       = disc_ff;
      drops_in      = drops_ff;
      limit_in      = limit_ff;
      remain_in     = remain_ff;
      drops_mid     = drops_ff;
      pop           = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pwp_ff;
      ram_wr_data   = WORD_BITS'(head.value);
      ram_rd_en     = 1'b0;
      ram_rd_addr   = rp_adv;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_kind_in   = out_kind_ff;
      out_status_in = out_status_ff;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;
      out_drops_in  = out_drops_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               unique case (head.op)
                  OP_BEGIN: begin
                     if (can_load) begin
                        pop           = 1'b1;
                        // An open message that is abandoned counts as dropped.
                        drops_mid     = sat_inc(drops_ff, !disc_ff && (wr_ff != '0));
                        drops_in      = drops_mid;
                        disc_in       = 1'b0;
                        wr_in         = '0;
                        pwp_in        = cwp_ff;
                        out_status_in = ST_OK;
                        if (head.over_max) begin
                           drops_in      = sat_inc(drops_mid, 1'b1);
                           out_status_in = ST_DROPPED;
                        end else if (cwp_adv == rp_ff) begin
                           // No room for the header: discard the announced words.
                           drops_in      = sat_inc(drops_mid, 1'b1);
                           wr_in         = head.value[LEN_BITS-1:0];
                           disc_in       = !head.zero_len;
                           out_status_in = ST_DROPPED;
                        end else begin
                           ram_wr_en   = 1'b1;
                           ram_wr_addr = cwp_ff;
                           pwp_in      = cwp_adv;
                           if (head.zero_len) begin
                              cwp_in = cwp_adv;
                           end else begin
                              wr_in = head.value[LEN_BITS-1:0];
                           end
                        end
                        out_valid_in = 1'b1;
                        out_kind_in  = KIND_SEND;
                        out_value_in = '0;
                        out_last_in  = 1'b1;
                        out_drops_in = drops_in;
                     end
                  end
                  OP_DATA: begin
                     if (can_load) begin
                        pop           = 1'b1;
                        out_status_in = ST_DROPPED;
                        if (disc_ff) begin
                           wr_in   = wr_dec;
                           disc_in = wr_dec != '0;
                        end else if (wr_ff == '0) begin
                           // No message open: the word is ignored.
                           wr_in = wr_ff;
                        end else if (pwp_adv == rp_ff) begin
                           // Ring full mid-message: roll back and discard the rest.
                           drops_in = sat_inc(drops_ff, 1'b1);
                           pwp_in   = cwp_ff;
                           wr_in    = wr_dec;
                           disc_in  = wr_dec != '0;
                        end else begin
                           ram_wr_en     = 1'b1;
                           ram_wr_addr   = pwp_ff;
                           pwp_in        = pwp_adv;
                           wr_in         = wr_dec;
                           out_status_in = ST_OK;
                           if (wr_dec == '0) begin
                              cwp_in = pwp_adv;
                           end
                        end
                        out_valid_in = 1'b1;
                        out_kind_in  = KIND_SEND;
                        out_value_in = '0;
                        out_last_in  = 1'b1;
                        out_drops_in = drops_in;
                     end
                  end
                  OP_READ: begin
                     if (rp_ff == cwp_ff) begin
                        if (can_load) begin
                           pop           = 1'b1;
                           out_valid_in  = 1'b1;
                           out_kind_in   = KIND_HEADER;
                           out_status_in = ST_EMPTY;
                           out_value_in  = '0;
                           out_last_in   = 1'b1;
                           out_drops_in  = drops_ff;
                        end
                     end else begin
                        // Fetch the header word of the oldest message.
                        pop         = 1'b1;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = rp_ff;
                        limit_in    = head.value;
                        state_in    = S_HDR;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         S_HDR: begin
            if (can_load) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_HEADER;
               out_value_in = VALUE_BITS'(hdr_len);
               out_drops_in = drops_ff;
               if (VALUE_BITS'(hdr_len) > limit_ff) begin
                  // Too large: report and leave the message in place.
                  out_status_in = ST_TOO_LARGE;
                  out_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  out_status_in = ST_OK;
                  out_last_in   = hdr_len == '0;
                  rp_in         = rp_adv;
                  if (hdr_len != '0) begin
                     ram_rd_en = 1'b1;
                     remain_in = hdr_len;
                     state_in  = S_STREAM;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_STREAM: begin
            // The read data holds the current word; fetch the next one as it leaves.
            if (can_load) begin
               out_valid_in  = 1'b1;
               out_kind_in   = KIND_DATA;
               out_status_in = ST_OK;
               out_value_in  = VALUE_BITS'(ram_rd_data[OUT_BITS-1:0]);
               out_last_in   = remain_ff == LEN_BITS'(1);
               out_drops_in  = drops_ff;
               rp_in         = rp_adv;
               remain_in     = remain_ff - 1'b1;
               if (remain_ff == LEN_BITS'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  ram_rd_en = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rp_ff        <= '0;
         cwp_ff       <= '0;
         pwp_ff       <= '0;
         wr_ff        <= '0;
         disc_ff      <= 1'b0;
         drops_ff     <= '0;
         remain_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         cwp_ff       <= cwp_in;
         pwp_ff       <= pwp_in;
         wr_ff        <= wr_in;
         disc_ff      <= disc_in;
         drops_ff     <= drops_in;
         remain_ff    <= remain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      limit_ff      <= limit_in;
      out_kind_ff   <= out_kind_in;
      out_status_ff <= out_status_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
      out_drops_ff  <= out_drops_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.kind       = out_kind_ff;
   assign rsp.status     = out_status_ff;
   assign rsp.value_res  = out_value_ff;
   assign rsp.last       = out_last_ff;
   assign rsp.drop_count = out_drops_ff;

   // Discarding always has announced words left to swallow.
   a_disc_has_words: assert property (@(posedge clock) disable iff (reset)
      disc_ff |-> (wr_ff != '0))
      else $error("discarding with no words remaining");

   // A stream in progress always has a word left to deliver.
   a_stream_has_words: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STREAM) |-> (remain_ff != '0))
      else $error("stream state with no words remaining");

   // No new command is taken while a read is in progress.
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !pop)
      else $error("queue popped during a read");

   // While a message is being read, the read position stays inside committed data.
   a_read_in_committed: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_HDR) || (state_ff == S_STREAM)) |-> (rp_ff != cwp_ff))
      else $error("read position reached the committed write position");

endmodule
